// ----- hdl/rtse_pkg.sv -----
// ----------------------------------------------------------------------------
// rtse_pkg
// Shared types and constants of the raw track sector extractor.
// ----------------------------------------------------------------------------
package rtse_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 13;

  // Track format bytes
  localparam logic [BYTE_W-1:0] GAP_BYTE       = 8'h4E;
  localparam logic [BYTE_W-1:0] SYNC_BYTE      = 8'h00;
  localparam logic [BYTE_W-1:0] LEAD_SYNC_BYTE = 8'hC2;
  localparam logic [BYTE_W-1:0] A1_BYTE        = 8'hA1;
  localparam logic [BYTE_W-1:0] ID_MARK        = 8'hFE;
  localparam logic [BYTE_W-1:0] DATA_MARK      = 8'hFB;

  typedef struct packed {
    logic               data_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] dest_index;
    logic               track_done;
    logic               track_ok;
  } rtse_res_t;

endpackage

// ----- hdl/rtse_parse.sv -----
// ----------------------------------------------------------------------------
// rtse_parse
// Track layout walker: one raw byte per word, next state and result in one pass.
// ----------------------------------------------------------------------------
module rtse_parse #(
  parameter int unsigned DEST_CAPACITY = 5120
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [rtse_pkg::BYTE_W-1:0]      raw_byte,
  input  logic                             last_byte,
  output logic                             res_valid,
  output rtse_pkg::rtse_res_t              res
);
  import rtse_pkg::*;

  localparam int unsigned WI_W = $clog2(DEST_CAPACITY + 1);
  localparam int unsigned FC_W = 11;

  typedef enum logic [3:0] {
    PH_LEAD_GAP, PH_LEAD_SYNC, PH_GAP, PH_SYNC_ID, PH_MARK_ID, PH_HEADER,
    PH_HDR_CRC, PH_GAP_DATA, PH_SYNC_DATA, PH_MARK_DATA, PH_DATA, PH_DATA_CRC
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        smc_r, smc_nxt;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [1:0]        sc_r, sc_nxt;
  logic [WI_W-1:0]   wi_r, wi_nxt;
  logic              failed_r, failed_nxt;
  logic              emit;
  logic              ok;
  logic [FC_W-1:0]   data_last;

  assign data_last = (FC_W'(128) << sc_r) - FC_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    smc_nxt    = smc_r;
    fc_nxt     = fc_r;
    sc_nxt     = sc_r;
    wi_nxt     = wi_r;
    failed_nxt = failed_r;
    emit       = 1'b0;
    if (!failed_r) begin
      // fall through the gap and sync phases on the same byte
      if (phase_nxt == PH_LEAD_GAP && raw_byte != GAP_BYTE) phase_nxt = PH_LEAD_SYNC;
      if (phase_nxt == PH_LEAD_SYNC && raw_byte != SYNC_BYTE &&
          raw_byte != LEAD_SYNC_BYTE) phase_nxt = PH_GAP;
      if (phase_nxt == PH_GAP && raw_byte != GAP_BYTE) phase_nxt = PH_SYNC_ID;
      if (phase_nxt == PH_SYNC_ID && raw_byte != SYNC_BYTE) begin
        phase_nxt = PH_MARK_ID;
        smc_nxt   = 2'd0;
      end
      if (phase_nxt == PH_GAP_DATA && raw_byte != GAP_BYTE) phase_nxt = PH_SYNC_DATA;
      if (phase_nxt == PH_SYNC_DATA && raw_byte != SYNC_BYTE) begin
        phase_nxt = PH_MARK_DATA;
        smc_nxt   = 2'd0;
      end
      case (phase_nxt)
        PH_LEAD_GAP, PH_LEAD_SYNC, PH_GAP, PH_SYNC_ID, PH_GAP_DATA, PH_SYNC_DATA: ;
        PH_MARK_ID, PH_MARK_DATA: begin
          if (raw_byte == A1_BYTE && smc_nxt != 2'd3) begin
            smc_nxt = smc_nxt + 2'd1;
          end else if (phase_nxt == PH_MARK_ID && raw_byte == ID_MARK) begin
            phase_nxt = PH_HEADER;
            fc_nxt    = '0;
          end else if (phase_nxt == PH_MARK_DATA && raw_byte == DATA_MARK) begin
            phase_nxt = PH_DATA;
            fc_nxt    = '0;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_HEADER: begin
          fc_nxt = fc_r + FC_W'(1);
          if (fc_r == FC_W'(3)) begin
            if (raw_byte inside {[8'd1:8'd3]}) begin
              sc_nxt    = raw_byte[1:0];
              phase_nxt = PH_HDR_CRC;
              fc_nxt    = '0;
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end
        PH_HDR_CRC, PH_DATA_CRC: begin
          fc_nxt = fc_r + FC_W'(1);
          if (fc_r == FC_W'(1)) begin
            phase_nxt = (phase_r == PH_HDR_CRC) ? PH_GAP_DATA : PH_GAP;
            fc_nxt    = '0;
          end
        end
        PH_DATA: begin
          // drop bytes past the end of the buffer, but keep counting them
          if (wi_r < WI_W'(DEST_CAPACITY)) begin
            emit   = 1'b1;
            wi_nxt = wi_r + WI_W'(1);
          end
          fc_nxt = fc_r + FC_W'(1);
          if (fc_r == data_last) begin
            phase_nxt = PH_DATA_CRC;
            fc_nxt    = '0;
          end
        end
        default: failed_nxt = 1'b1;
      endcase
    end
    ok = !failed_nxt && ((phase_nxt inside {PH_LEAD_GAP, PH_LEAD_SYNC, PH_GAP}) ||
                         (phase_nxt == PH_DATA_CRC && fc_nxt != '0));
  end

  always_comb begin
    res_valid      = accept && (emit || last_byte);
    res.data_valid = emit;
    res.data_byte  = emit ? raw_byte : '0;
    res.dest_index = emit ? INDEX_W'(wi_r) : '0;
    res.track_done = last_byte;
    res.track_ok   = last_byte && ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      phase_r  <= PH_LEAD_GAP;
      smc_r    <= 2'd0;
      fc_r     <= '0;
      sc_r     <= 2'd0;
      wi_r     <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      smc_r    <= smc_nxt;
      fc_r     <= fc_nxt;
      sc_r     <= sc_nxt;
      wi_r     <= wi_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ----- hdl/rtse_out_reg.sv -----
// ----------------------------------------------------------------------------
// rtse_out_reg
// Result register: holds one word until the downstream side takes it.
// ----------------------------------------------------------------------------
module rtse_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  rtse_pkg::rtse_res_t res,
  input  logic                out_stall,
  output logic                busy,
  output logic                out_valid,
  output rtse_pkg::rtse_res_t out_res
);
  import rtse_pkg::*;

  logic      valid_r;
  rtse_res_t res_r;
  logic      load;

  // free when empty or when the held word leaves this cycle
  assign load      = !valid_r || !out_stall;
  assign busy      = !load;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ----- hdl/raw_track_sector_extractor.sv -----
// ----------------------------------------------------------------------------
// raw_track_sector_extractor
// Walks an IBM-layout raw track and emits sector data bytes with their index.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle while in_stall is low. The layout walker is
// combinational and its state registers are updated at the accepting edge; the
// result (a sector byte, an end-of-track report, or both) is loaded into a single
// output register at that edge and sits there in the next cycle. Input is taken
// whenever that register is empty or being drained, so a full stream runs at one
// byte per clock while the output is not stalled. Bytes that produce no result (gaps, marks, CRCs) leave
// nothing on the output. CRCs are not checked; the track state clears after
// the word flagged as the last byte.
module raw_track_sector_extractor #(
  parameter int unsigned DEST_CAPACITY = 5120
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rtse_pkg::BYTE_W-1:0]       in_raw_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_data_valid,
  output logic [rtse_pkg::BYTE_W-1:0]       out_data_byte,
  output logic [rtse_pkg::INDEX_W-1:0]      out_dest_index,
  output logic                              out_track_done,
  output logic                              out_track_ok
);
  import rtse_pkg::*;

  logic      accept;
  logic      res_valid;
  logic      busy;
  rtse_res_t res;
  rtse_res_t out_res;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  rtse_parse #(
    .DEST_CAPACITY(DEST_CAPACITY)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .raw_byte (in_raw_byte),
    .last_byte(in_last_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  rtse_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .out_stall(out_stall),
    .busy     (busy),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  assign out_data_valid = out_res.data_valid;
  assign out_data_byte  = out_res.data_byte;
  assign out_dest_index = out_res.dest_index;
  assign out_track_done = out_res.track_done;
  assign out_track_ok   = out_res.track_ok;

  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_track_ok |-> out_track_done)
    else $error("track_ok without track_done");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data_valid || out_track_done)
    else $error("empty result word");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> out_data_byte == '0 && out_dest_index == '0)
    else $error("data fields set without data_valid");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> 32'(out_dest_index) < DEST_CAPACITY)
    else $error("dest_index beyond capacity");

endmodule

// ----- dv/raw_track_sector_extractor_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_track_sector_extractor_checker
// Follows every accepted raw track word through the track layout, builds the
// sector bytes and end-of-track reports the block must return, and compares
// each accepted result word against the oldest outstanding one.
// ----------------------------------------------------------------------------
module raw_track_sector_extractor_checker #(
  parameter int unsigned DEST_CAPACITY = 5120
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rtse_pkg::BYTE_W-1:0]  in_raw_byte,
  input  logic                         in_last_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_data_valid,
  input  logic [rtse_pkg::BYTE_W-1:0]  out_data_byte,
  input  logic [rtse_pkg::INDEX_W-1:0] out_dest_index,
  input  logic                         out_track_done,
  input  logic                         out_track_ok,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);
  import rtse_pkg::*;

  localparam int unsigned MAX_MARKS    = 3;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned CRC_BYTES    = 2;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [BYTE_W-1:0] SIZE_MIN = 8'd1;
  localparam logic [BYTE_W-1:0] SIZE_MAX = 8'd3;

  typedef enum logic [3:0] {
    PH_LEAD_GAP, PH_LEAD_SYNC, PH_GAP, PH_SYNC_ID, PH_MARK_ID, PH_HEADER,
    PH_HDR_CRC, PH_GAP_DATA, PH_SYNC_DATA, PH_MARK_DATA, PH_DATA, PH_DATA_CRC
  } track_phase_t;

  track_phase_t phase;
  int unsigned  mark_cnt;
  int unsigned  field_cnt;
  logic [1:0]   size_code;
  int unsigned  wr_index;
  logic         track_bad;
  rtse_res_t    sector_out_q[$];
  int unsigned  errors = 0;

  assign fail_count = errors;

  function automatic void clear_track();
    phase     = PH_LEAD_GAP;
    mark_cnt  = 0;
    field_cnt = 0;
    size_code = '0;
    wr_index  = 0;
    track_bad = 1'b0;
  endfunction

  // Walk one raw byte; a byte that ends a skippable run is re-examined by the
  // next phase in the same step.
  function automatic void walk_byte(input logic [BYTE_W-1:0] b, output logic emit,
                                    output logic [INDEX_W-1:0] idx);
    logic again;
    emit  = 1'b0;
    idx   = '0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (phase)
        PH_LEAD_GAP: if (b != GAP_BYTE) begin
          phase = PH_LEAD_SYNC;
          again = 1'b1;
        end
        PH_LEAD_SYNC: if (b != SYNC_BYTE && b != LEAD_SYNC_BYTE) begin
          phase = PH_GAP;
          again = 1'b1;
        end
        PH_GAP: if (b != GAP_BYTE) begin
          phase = PH_SYNC_ID;
          again = 1'b1;
        end
        PH_SYNC_ID: if (b != SYNC_BYTE) begin
          phase    = PH_MARK_ID;
          mark_cnt = 0;
          again    = 1'b1;
        end
        PH_MARK_ID: begin
          if (b == A1_BYTE && mark_cnt < MAX_MARKS) mark_cnt++;
          else if (b == ID_MARK) begin
            phase     = PH_HEADER;
            field_cnt = 0;
          end else track_bad = 1'b1;
        end
        PH_HEADER: begin
          field_cnt++;
          if (field_cnt >= HEADER_BYTES) begin
            if (b >= SIZE_MIN && b <= SIZE_MAX) begin
              size_code = b[1:0];
              phase     = PH_HDR_CRC;
              field_cnt = 0;
            end else track_bad = 1'b1;
          end
        end
        PH_HDR_CRC: begin
          field_cnt++;
          if (field_cnt >= CRC_BYTES) begin
            phase     = PH_GAP_DATA;
            field_cnt = 0;
          end
        end
        PH_GAP_DATA: if (b != GAP_BYTE) begin
          phase = PH_SYNC_DATA;
          again = 1'b1;
        end
        PH_SYNC_DATA: if (b != SYNC_BYTE) begin
          phase    = PH_MARK_DATA;
          mark_cnt = 0;
          again    = 1'b1;
        end
        PH_MARK_DATA: begin
          if (b == A1_BYTE && mark_cnt < MAX_MARKS) mark_cnt++;
          else if (b == DATA_MARK) begin
            phase     = PH_DATA;
            field_cnt = 0;
          end else track_bad = 1'b1;
        end
        PH_DATA: begin
          // past the buffer end, consume without emitting
          if (wr_index < DEST_CAPACITY) begin
            emit = 1'b1;
            idx  = wr_index[INDEX_W-1:0];
            wr_index++;
          end
          field_cnt++;
          if (field_cnt >= (128 << size_code)) begin
            phase     = PH_DATA_CRC;
            field_cnt = 0;
          end
        end
        PH_DATA_CRC: begin
          field_cnt++;
          if (field_cnt >= CRC_BYTES) begin
            phase     = PH_GAP;
            field_cnt = 0;
          end
        end
        default: track_bad = 1'b1;
      endcase
    end
  endfunction

  function automatic void predict_word(input logic [BYTE_W-1:0] b, input logic last);
    rtse_res_t              want;
    logic                   emit;
    logic [INDEX_W-1:0]     idx;
    logic                   clean_end;
    emit = 1'b0;
    idx  = '0;
    if (!track_bad) walk_byte(b, emit, idx);
    if (emit || last) begin
      clean_end = phase == PH_LEAD_GAP || phase == PH_LEAD_SYNC || phase == PH_GAP ||
                  (phase == PH_DATA_CRC && field_cnt != 0);
      want.data_valid = emit;
      want.data_byte  = emit ? b : '0;
      want.dest_index = idx;
      want.track_done = last;
      want.track_ok   = last && !track_bad && clean_end;
      sector_out_q.push_back(want);
    end
    if (last) clear_track();
  endfunction

  function automatic void report(input string what, input rtse_res_t want,
                                 input rtse_res_t got, input logic has_want);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      if (has_want)
        $display("%0t %s: expected valid=%0b byte=%02h index=%0d done=%0b ok=%0b",
                 $time, what, want.data_valid, want.data_byte, want.dest_index,
                 want.track_done, want.track_ok);
      $display("%0t %s: actual   valid=%0b byte=%02h index=%0d done=%0b ok=%0b",
               $time, what, got.data_valid, got.data_byte, got.dest_index,
               got.track_done, got.track_ok);
    end
  endfunction

  always @(posedge clk) begin
    rtse_res_t got;
    rtse_res_t want;
    if (!rst_n) begin
      clear_track();
      sector_out_q.delete();
    end else begin
      // retire results before taking new words, since every result is registered
      if (out_valid && !out_stall) begin
        got.data_valid = out_data_valid;
        got.data_byte  = out_data_byte;
        got.dest_index = out_dest_index;
        got.track_done = out_track_done;
        got.track_ok   = out_track_ok;
        if (sector_out_q.size() == 0) begin
          want = '0;
          report("unexpected result", want, got, 1'b0);
        end else begin
          want = sector_out_q.pop_front();
          if (got !== want) report("result mismatch", want, got, 1'b1);
        end
      end
      if (in_valid && !in_stall) predict_word(in_raw_byte, in_last_byte);
    end
    pending <= sector_out_q.size();
  end

endmodule

// ----- dv/raw_track_sector_extractor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raw_track_sector_extractor_tb
// Feeds raw tracks to the extractor: a few short hand-built tracks that hit
// the layout corners, then random tracks that are mostly well formed, some
// truncated, corrupted or pure noise, with random gaps on the input and
// random stalls on the output. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module raw_track_sector_extractor_tb;
  import rtse_pkg::*;

  localparam int unsigned DEST_CAPACITY  = 5120;
  localparam int unsigned RANDOM_WORDS   = 2000;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam logic [BYTE_W-1:0] SIZE_256 = 8'd1;
  localparam logic [BYTE_W-1:0] SIZE_512 = 8'd2;
  localparam logic [BYTE_W-1:0] SIZE_1K  = 8'd3;
  localparam logic [BYTE_W-1:0] BAD_SIZE = 8'd0;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_raw_byte  = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               out_data_valid;
  logic [BYTE_W-1:0]  out_data_byte;
  logic [INDEX_W-1:0] out_dest_index;
  logic               out_track_done;
  logic               out_track_ok;
  int unsigned        fail_count;
  int unsigned        pending;

  logic               idle_on      = 1'b0;
  int unsigned        stall_left   = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        sent         = 0;
  logic [BYTE_W-1:0]  trk[$];

  always #2 clk = ~clk;

  raw_track_sector_extractor #(
    .DEST_CAPACITY(DEST_CAPACITY)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_byte    (in_raw_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_valid (out_data_valid),
    .out_data_byte  (out_data_byte),
    .out_dest_index (out_dest_index),
    .out_track_done (out_track_done),
    .out_track_ok   (out_track_ok)
  );

  raw_track_sector_extractor_checker #(
    .DEST_CAPACITY(DEST_CAPACITY)
  ) track_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_byte    (in_raw_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_valid (out_data_valid),
    .out_data_byte  (out_data_byte),
    .out_dest_index (out_dest_index),
    .out_track_done (out_track_done),
    .out_track_ok   (out_track_ok),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Output stalls in random bursts, started only while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_byte  <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_track();
    for (int i = 0; i < trk.size(); i++) send_word(trk[i], i == trk.size() - 1);
    sent += trk.size();
    trk.delete();
  endtask

  // Hold the input until every outstanding result has drained.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic void put_run(input logic [BYTE_W-1:0] b, input int unsigned n);
    repeat (n) trk.push_back(b);
  endfunction

  function automatic void put_lead();
    put_run(GAP_BYTE, $urandom_range(0, 5));
    repeat ($urandom_range(0, 3)) trk.push_back($urandom_range(0, 1) ? SYNC_BYTE : LEAD_SYNC_BYTE);
  endfunction

  function automatic void put_sector(input logic [BYTE_W-1:0] szc, input int unsigned id_a1,
                                     input int unsigned data_a1);
    int unsigned n;
    put_run(GAP_BYTE, $urandom_range(0, 4));
    put_run(SYNC_BYTE, $urandom_range(0, 3));
    put_run(A1_BYTE, id_a1);
    trk.push_back(ID_MARK);
    repeat (3) trk.push_back(8'($urandom));
    trk.push_back(szc);
    repeat (2) trk.push_back(8'($urandom));
    put_run(GAP_BYTE, $urandom_range(0, 3));
    put_run(SYNC_BYTE, $urandom_range(0, 3));
    put_run(A1_BYTE, data_a1);
    trk.push_back(DATA_MARK);
    n = (szc >= SIZE_256 && szc <= SIZE_1K) ? (128 << szc) : 16;
    repeat (n + 2) trk.push_back(8'($urandom));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    return (r < 16) ? SIZE_256 : (r < 19) ? SIZE_512 : SIZE_1K;
  endfunction

  initial begin
    int unsigned kind;
    int unsigned pos;
    logic [BYTE_W-1:0] szc;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Track ends in the leading gap, then in the leading sync.
    trk = '{GAP_BYTE};
    send_track();
    trk = '{GAP_BYTE, LEAD_SYNC_BYTE};
    send_track();
    // Fourth A1 before the ID mark; later bytes are ignored.
    trk = '{GAP_BYTE, SYNC_BYTE, A1_BYTE, A1_BYTE, A1_BYTE, A1_BYTE, ID_MARK};
    send_track();
    // Size code out of range, track ends on it.
    trk = '{ID_MARK, 8'hFF, 8'h00, 8'h80, BAD_SIZE};
    send_track();
    // Wrong mark after the sync.
    trk = '{SYNC_BYTE, A1_BYTE, 8'h55};
    send_track();
    // Track ends right after the header CRC.
    trk = '{ID_MARK, 8'hFF, 8'h00, 8'h80, SIZE_1K, 8'h12, 8'h34};
    send_track();
    drain();

    while (sent < RANDOM_WORDS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      put_lead();
      case (kind)
        5: begin
          // truncate anywhere
          put_sector(pick_size(), $urandom_range(0, 3), $urandom_range(0, 3));
          repeat ($urandom_range(1, trk.size() - 1)) void'(trk.pop_back());
        end
        6: begin
          // end on the last data byte or on the first data CRC byte
          put_sector(pick_size(), $urandom_range(0, 3), $urandom_range(0, 3));
          repeat ($urandom_range(1, 2)) void'(trk.pop_back());
        end
        7: begin
          put_sector(pick_size(), $urandom_range(0, 3), $urandom_range(0, 3));
          pos = $urandom_range(0, (trk.size() > 40) ? 40 : trk.size() - 1);
          trk[pos] = 8'($urandom);
        end
        8: begin
          case ($urandom_range(0, 2))
            0: put_sector(pick_size(), 4, $urandom_range(0, 3));
            1: put_sector(pick_size(), $urandom_range(0, 3), 4);
            default: begin
              szc = $urandom_range(0, 1) ? BAD_SIZE : 8'($urandom_range(4, 255));
              put_sector(szc, $urandom_range(0, 3), $urandom_range(0, 3));
            end
          endcase
          put_run(GAP_BYTE, $urandom_range(0, 2));
        end
        9: begin
          trk.delete();
          repeat ($urandom_range(1, 40)) trk.push_back(8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 2))
            put_sector(pick_size(), $urandom_range(0, 3), $urandom_range(0, 3));
          put_run(GAP_BYTE, $urandom_range(0, 3));
        end
      endcase
      send_track();
    end
    drain();

    // Back-to-back tail with no idling on either side.
    idle_on = 1'b0;
    repeat (2) begin
      put_lead();
      put_sector(pick_size(), $urandom_range(0, 3), $urandom_range(0, 3));
      put_run(GAP_BYTE, 1);
      send_track();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
